### hdl/crc16_frame_deframer_defines.svh
// assertion macros shared by the deframer checks
`ifndef CRC16_FRAME_DEFRAMER_DEFINES_SVH
`define CRC16_FRAME_DEFRAMER_DEFINES_SVH

// implication in the same cycle, off while reset is high
`define CRCDF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, off while reset is high
`define CRCDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication in the next cycle, always checked
`define CRCDF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/crcdf_pkg.sv
// shared types, constants and the crc function of the deframer
package crcdf_pkg;

   localparam logic [7:0]  HEAD_CHAR = 8'h3C;   // '<'
   localparam logic [7:0]  TAIL_CHAR = 8'h3E;   // '>'
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [15:0] CRC_LSB   = 16'h0001;

   // frame handed from the parser to the readout engine
   typedef struct packed {
      logic       start;
      logic [7:0] channel;
      logic [7:0] flags;
      logic [6:0] length;
   } frame_start_type;

   // crc-16/arc, reflected, one byte
   function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_LSB) != 16'h0000) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### hdl/crcdf_store.sv
// payload store: one write port, one registered read port
module crcdf_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/crcdf_parser.sv
// byte parser: header hunt, fields, payload write, crc and tail check
module crcdf_parser #(
   parameter int MAX_PAYLOAD = 64,
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               rx_byte,
   input  logic                     chunk_end,
   output logic                     wr_en,
   output logic [AW-1:0]            wr_addr,
   output logic [7:0]               wr_data,
   output crcdf_pkg::frame_start_type frame_start
);
   import crcdf_pkg::*;

   localparam logic [3:0] ST_HEAD_A = 4'd0;
   localparam logic [3:0] ST_HEAD_B = 4'd1;
   localparam logic [3:0] ST_CHAN   = 4'd2;
   localparam logic [3:0] ST_FLAGS  = 4'd3;
   localparam logic [3:0] ST_LEN_LO = 4'd4;
   localparam logic [3:0] ST_LEN_HI = 4'd5;
   localparam logic [3:0] ST_DATA   = 4'd6;
   localparam logic [3:0] ST_CRC_LO = 4'd7;
   localparam logic [3:0] ST_CRC_HI = 4'd8;
   localparam logic [3:0] ST_TAIL_A = 4'd9;
   localparam logic [3:0] ST_TAIL_B = 4'd10;

   localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

   logic [3:0]    state_ff, state_in;
   logic [7:0]    chan_ff, chan_in;
   logic [7:0]    flags_ff, flags_in;
   logic [7:0]    len_lo_ff, len_lo_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] widx_ff, widx_in;
   logic [15:0]   rx_crc_ff, rx_crc_in;
   logic [15:0]   run_crc_ff, run_crc_in;
   logic [15:0]   full_len;
   logic [CW-1:0] widx_next;

   assign full_len  = {rx_byte, len_lo_ff};
   assign widx_next = widx_ff + CW'(1);

   always_comb begin
      state_in    = state_ff;
      chan_in     = chan_ff;
      flags_in    = flags_ff;
      len_lo_in   = len_lo_ff;
      len_in      = len_ff;
      widx_in     = widx_ff;
      rx_crc_in   = rx_crc_ff;
      run_crc_in  = run_crc_ff;
      wr_en       = 1'b0;
      frame_start = '{start: 1'b0, channel: chan_ff, flags: flags_ff,
                      length: 7'(len_ff)};
      if (accept) begin
         case (state_ff)
            ST_HEAD_A: state_in = (rx_byte == HEAD_CHAR) ? ST_HEAD_B : ST_HEAD_A;
            ST_HEAD_B: state_in = (rx_byte == HEAD_CHAR) ? ST_CHAN : ST_HEAD_A;
            ST_CHAN: begin
               chan_in  = rx_byte;
               state_in = ST_FLAGS;
            end
            ST_FLAGS: begin
               flags_in = rx_byte;
               state_in = ST_LEN_LO;
            end
            ST_LEN_LO: begin
               len_lo_in = rx_byte;
               state_in  = ST_LEN_HI;
            end
            ST_LEN_HI: begin
               len_in     = full_len[CW-1:0];
               widx_in    = '0;
               run_crc_in = '0;
               if (full_len > MaxLen) begin
                  state_in = ST_HEAD_A;
               end else if (full_len == 16'h0000) begin
                  state_in = ST_CRC_LO;
               end else begin
                  state_in = ST_DATA;
               end
            end
            ST_DATA: begin
               wr_en      = 1'b1;
               run_crc_in = crc_arc_byte(run_crc_ff, rx_byte);
               widx_in    = widx_next;
               if (widx_next >= len_ff) begin
                  state_in = ST_CRC_LO;
               end
            end
            ST_CRC_LO: begin
               rx_crc_in = {8'h00, rx_byte};
               state_in  = ST_CRC_HI;
            end
            ST_CRC_HI: begin
               rx_crc_in = {rx_byte, rx_crc_ff[7:0]};
               state_in  = ST_TAIL_A;
            end
            ST_TAIL_A: state_in = (rx_byte == TAIL_CHAR) ? ST_TAIL_B : ST_HEAD_A;
            ST_TAIL_B: begin
               state_in = ST_HEAD_A;
               frame_start.start = (rx_byte == TAIL_CHAR) && (rx_crc_ff == run_crc_ff);
            end
            default: state_in = ST_HEAD_A;
         endcase
         if (chunk_end) begin
            state_in = ST_HEAD_A;
         end
      end
   end

   assign wr_addr = widx_ff[AW-1:0];
   assign wr_data = rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_HEAD_A;
         chan_ff    <= '0;
         flags_ff   <= '0;
         len_lo_ff  <= '0;
         len_ff     <= '0;
         widx_ff    <= '0;
         rx_crc_ff  <= '0;
         run_crc_ff <= '0;
      end else begin
         state_ff   <= state_in;
         chan_ff    <= chan_in;
         flags_ff   <= flags_in;
         len_lo_ff  <= len_lo_in;
         len_ff     <= len_in;
         widx_ff    <= widx_in;
         rx_crc_ff  <= rx_crc_in;
         run_crc_ff <= run_crc_in;
      end
   end

endmodule

### hdl/crcdf_readout.sv
// readout engine: reads a good frame from the store into a two-stage output pipe
module crcdf_readout #(
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  crcdf_pkg::frame_start_type frame_start,
   output logic                       busy,
   output logic                       rd_en,
   output logic [AW-1:0]              rd_addr,
   input  logic [7:0]                 rd_data,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,
   output logic                       rsp_tlast,
   output logic [0:0]                 rsp_tuser
);
   import crcdf_pkg::*;

   logic          active_ff, active_in;
   logic          empty_ff, empty_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [7:0]    m_chan_ff, m_chan_in;
   logic [7:0]    m_flags_ff, m_flags_in;
   logic [6:0]    m_len_ff, m_len_in;

   // read stage: data sits in the store's read register
   logic          rd_vld_ff, rd_vld_in;
   logic          rd_bv_ff, rd_last_ff;
   logic [7:0]    rd_chan_ff, rd_flags_ff;
   logic [6:0]    rd_len_ff;

   // output register
   logic          out_vld_ff, out_vld_in;
   logic          out_bv_ff, out_last_ff;
   logic [7:0]    out_chan_ff, out_flags_ff, out_byte_ff;
   logic [6:0]    out_len_ff;

   logic out_free, move, issue, rem_one;

   assign out_free = !out_vld_ff || rsp_tready;
   assign move     = rd_vld_ff && out_free;
   assign issue    = active_ff && (!rd_vld_ff || move);
   assign rem_one  = (rem_ff == CW'(1));

   assign busy    = active_ff;
   assign rd_en   = issue && !empty_ff;
   assign rd_addr = idx_ff;

   always_comb begin
      active_in  = active_ff;
      empty_in   = empty_ff;
      rem_in     = rem_ff;
      idx_in     = idx_ff;
      m_chan_in  = m_chan_ff;
      m_flags_in = m_flags_ff;
      m_len_in   = m_len_ff;
      if (frame_start.start) begin
         active_in  = 1'b1;
         empty_in   = (frame_start.length == 7'd0);
         rem_in     = (frame_start.length == 7'd0) ? CW'(1) : CW'(frame_start.length);
         idx_in     = '0;
         m_chan_in  = frame_start.channel;
         m_flags_in = frame_start.flags;
         m_len_in   = frame_start.length;
      end else if (issue) begin
         rem_in = rem_ff - CW'(1);
         idx_in = idx_ff + AW'(1);
         if (rem_one) begin
            active_in = 1'b0;
         end
      end
      rd_vld_in  = issue || (rd_vld_ff && !move);
      out_vld_in = move || (out_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      empty_ff   <= empty_in;
      rem_ff     <= rem_in;
      idx_ff     <= idx_in;
      m_chan_ff  <= m_chan_in;
      m_flags_ff <= m_flags_in;
      m_len_ff   <= m_len_in;
      if (issue) begin
         rd_bv_ff    <= !empty_ff;
         rd_last_ff  <= rem_one;
         rd_chan_ff  <= m_chan_ff;
         rd_flags_ff <= m_flags_ff;
         rd_len_ff   <= m_len_ff;
      end
      if (move) begin
         out_bv_ff    <= rd_bv_ff;
         out_last_ff  <= rd_last_ff;
         out_chan_ff  <= rd_chan_ff;
         out_flags_ff <= rd_flags_ff;
         out_len_ff   <= rd_len_ff;
         out_byte_ff  <= rd_bv_ff ? rd_data : 8'h00;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_byte_ff, out_len_ff, out_flags_ff, out_chan_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_bv_ff;

endmodule

### hdl/crc16_frame_deframer.sv
// top level of the crc-16/arc checked frame deframer
//
// req channel: one received byte per transfer, tdata[7:0] the byte, tlast
// marks the end of a receive chunk and sends the parser back to header hunt.
// rsp channel: one transfer per payload byte of a good frame, in order, with
// channel, flags and length repeated on each; tlast marks the final byte.
// a good empty frame gives one transfer with tuser low and a zero byte.
// the parser takes one byte per cycle while req_tready is high. once the
// tail of a good frame is taken, req_tready stays low while the readout
// engine issues one store read per cycle unless the rsp side stalls; the
// single read port of the payload store sets this rate. the readout starts
// at the active flag; results go through the store's read register and
// the output register, one per cycle while rsp_tready is high. a stalled
// rsp side holds its transfer and at most one more in the read register;
// further reads wait. bad frames give nothing. reset clears the parser to
// header hunt and empties the output pipe; the payload store needs no
// clearing since only bytes of the current frame are read back.
module crc16_frame_deframer #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // chunk_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] channel, [15:8] frame_flags,
                                    // [22:16] payload_length, [30:23] payload_byte
   output logic        rsp_tlast,   // last
   output logic [0:0]  rsp_tuser    // [0] byte_valid
);
   import crcdf_pkg::*;

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CW = $clog2(MAX_PAYLOAD + 1);

   logic            accept;
   logic            busy;
   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [7:0]      wr_data, rd_data;
   frame_start_type frame_start;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   crcdf_parser #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW), .CW(CW)) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_tdata),
      .chunk_end   (req_tlast),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .frame_start (frame_start)
   );

   crcdf_store #(.DEPTH(MAX_PAYLOAD), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   crcdf_readout #(.AW(AW), .CW(CW)) u_readout (
      .clock       (clock),
      .reset       (reset),
      .frame_start (frame_start),
      .busy        (busy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

### hdl/crcdf_checker.sv
// port-level checks of the deframer and their bind
`include "crc16_frame_deframer_defines.svh"

module crcdf_checker #(
   parameter int MAX_PAYLOAD = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   localparam logic [6:0] MaxLen = 7'(MAX_PAYLOAD);

   // a stalled result transfer keeps its contents
   `CRCDF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "rsp transfer changed while stalled")

   // an empty frame is a single closing transfer with a zero byte and length
   `CRCDF_ASSERT_SAME(a_empty_frame, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tlast && (rsp_tdata[30:16] == 15'h0000), "empty frame result malformed")

   // reported length never exceeds the store, and the pad bit stays zero
   `CRCDF_ASSERT_SAME(a_len_range, clock, reset, rsp_tvalid, (rsp_tdata[22:16] <= MaxLen) && !rsp_tdata[31], "rsp length out of range")

   // nothing is offered right after reset
   `CRCDF_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "rsp valid after reset")

   // input held off right after a transfer means a readout, which is then offered
   `CRCDF_ASSERT_NEXT(a_ready_back, clock, reset, !$past(req_tready) && $past(req_tvalid && req_tready, 2), rsp_tvalid, "input held off with no readout")

endmodule

bind crc16_frame_deframer crcdf_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_crcdf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
